// ----- rtl/dual_vertex_edge_centroid_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dual vertex edge centroid block
// Shorthand for implication and next-cycle properties on one clock.
// ----------------------------------------------------------------------------
`ifndef DUAL_VERTEX_EDGE_CENTROID_TOP_ASSERT_SVH
`define DUAL_VERTEX_EDGE_CENTROID_TOP_ASSERT_SVH

// same-cycle implication
`define DVEC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dvec assertion failed");

// next-cycle implication
`define DVEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dvec assertion failed");

`endif

// ----- rtl/dvec_pkg.sv -----
// ----------------------------------------------------------------------------
// dvec_pkg
// Shared constants and cube edge tables for the dual vertex centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package dvec_pkg;

   localparam int COORD_BITS_DEF  = 10;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int SCALAR_BITS_DEF = 16;

   localparam int DIMENSION      = 3;
   localparam int NUM_CORNERS    = 8;
   localparam int NUM_EDGES      = 12;
   localparam int EDGES_PER_AXIS = 4;
   localparam int COUNT_BITS     = 4;
   localparam int REM_BITS       = 4;

   // lower corner of each edge, edges grouped by axis x, y, z
   localparam logic [2:0] EDGE_LO_CORNER [NUM_EDGES] = '{
      3'd0, 3'd2, 3'd4, 3'd6,
      3'd0, 3'd1, 3'd4, 3'd5,
      3'd0, 3'd1, 3'd2, 3'd3
   };

   localparam logic [1:0] EDGE_AXIS [NUM_EDGES] = '{
      2'd0, 2'd0, 2'd0, 2'd0,
      2'd1, 2'd1, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd2, 2'd2
   };

   function automatic logic [2:0] edge_hi_corner(input int e);
      return EDGE_LO_CORNER[e] | (3'd1 << EDGE_AXIS[e]);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/dvec_if.sv -----
// ----------------------------------------------------------------------------
// dvec channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvec_req_if #(
   parameter int COORD_BITS  = dvec_pkg::COORD_BITS_DEF,
   parameter int SCALAR_BITS = dvec_pkg::SCALAR_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic        [COORD_BITS-1:0]  cube_x;
   logic        [COORD_BITS-1:0]  cube_y;
   logic        [COORD_BITS-1:0]  cube_z;
   logic signed [SCALAR_BITS-1:0] corner_value_0;
   logic signed [SCALAR_BITS-1:0] corner_value_1;
   logic signed [SCALAR_BITS-1:0] corner_value_2;
   logic signed [SCALAR_BITS-1:0] corner_value_3;
   logic signed [SCALAR_BITS-1:0] corner_value_4;
   logic signed [SCALAR_BITS-1:0] corner_value_5;
   logic signed [SCALAR_BITS-1:0] corner_value_6;
   logic signed [SCALAR_BITS-1:0] corner_value_7;

   modport source (output valid, cube_x, cube_y, cube_z, corner_value_0, corner_value_1,
                   corner_value_2, corner_value_3, corner_value_4, corner_value_5,
                   corner_value_6, corner_value_7, input ready);
   modport sink (input valid, cube_x, cube_y, cube_z, corner_value_0, corner_value_1,
                 corner_value_2, corner_value_3, corner_value_4, corner_value_5,
                 corner_value_6, corner_value_7, output ready);
endinterface

interface dvec_rsp_if #(
   parameter int POS_BITS = dvec_pkg::COORD_BITS_DEF + dvec_pkg::FRAC_BITS_DEF + 1
);
   logic                            valid;
   logic                            ready;
   logic [POS_BITS-1:0]             pos_x;
   logic [POS_BITS-1:0]             pos_y;
   logic [POS_BITS-1:0]             pos_z;
   logic [dvec_pkg::COUNT_BITS-1:0] crossing_count;

   modport source (output valid, pos_x, pos_y, pos_z, crossing_count, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, crossing_count, output ready);
endinterface

interface dvec_csr_if #(
   parameter int SCALAR_BITS = dvec_pkg::SCALAR_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SCALAR_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dvec_prep.sv -----
// ----------------------------------------------------------------------------
// dvec_prep
// Classifies corners against the isovalue and forms per-edge divide operands.
// ----------------------------------------------------------------------------
`default_nettype none

module dvec_prep #(
   parameter int COORD_BITS  = dvec_pkg::COORD_BITS_DEF,
   parameter int SCALAR_BITS = dvec_pkg::SCALAR_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic signed [SCALAR_BITS-1:0]                    iso_level,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]   in_base,
   input  logic signed [SCALAR_BITS-1:0]                    in_corner [dvec_pkg::NUM_CORNERS],
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]   out_base,
   output logic [dvec_pkg::NUM_EDGES-1:0]                   out_cross,
   output logic [SCALAR_BITS-1:0]                           out_num [dvec_pkg::NUM_EDGES],
   output logic [SCALAR_BITS-1:0]                           out_den [dvec_pkg::NUM_EDGES]
);

   logic                                  valid_ff;
   logic [dvec_pkg::NUM_CORNERS-1:0]      positive;
   logic [dvec_pkg::NUM_EDGES-1:0]        cross_in;
   logic [SCALAR_BITS-1:0]                num_in [dvec_pkg::NUM_EDGES];
   logic [SCALAR_BITS-1:0]                den_in [dvec_pkg::NUM_EDGES];

   always_comb begin
      for (int k = 0; k < dvec_pkg::NUM_CORNERS; k++) begin
         positive[k] = in_corner[k] >= iso_level;
      end
   end

   for (genvar e = 0; e < dvec_pkg::NUM_EDGES; e++) begin : g_edge
      localparam logic [2:0] K0 = dvec_pkg::EDGE_LO_CORNER[e];
      localparam logic [2:0] K1 = dvec_pkg::edge_hi_corner(e);
      logic [SCALAR_BITS:0] num_diff;
      logic [SCALAR_BITS:0] num_neg;
      logic [SCALAR_BITS:0] den_diff;
      logic [SCALAR_BITS:0] den_neg;

      assign num_diff = {iso_level[SCALAR_BITS-1], iso_level}
                      - {in_corner[K0][SCALAR_BITS-1], in_corner[K0]};
      assign den_diff = {in_corner[K1][SCALAR_BITS-1], in_corner[K1]}
                      - {in_corner[K0][SCALAR_BITS-1], in_corner[K0]};
      assign num_neg  = -num_diff;
      assign den_neg  = -den_diff;
      assign num_in[e] = num_diff[SCALAR_BITS] ? num_neg[SCALAR_BITS-1:0]
                                               : num_diff[SCALAR_BITS-1:0];
      assign den_in[e] = den_diff[SCALAR_BITS] ? den_neg[SCALAR_BITS-1:0]
                                               : den_diff[SCALAR_BITS-1:0];
      assign cross_in[e] = positive[K0] ^ positive[K1];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         out_base  <= in_base;
         out_cross <= cross_in;
         out_num   <= num_in;
         out_den   <= den_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dvec_edge_div.sv -----
// ----------------------------------------------------------------------------
// dvec_edge_div
// Twelve-lane restoring divider, one quotient bit per stage, for edge crossings.
// ----------------------------------------------------------------------------
`default_nettype none

module dvec_edge_div #(
   parameter int COORD_BITS  = dvec_pkg::COORD_BITS_DEF,
   parameter int SCALAR_BITS = dvec_pkg::SCALAR_BITS_DEF,
   parameter int FRAC_BITS   = dvec_pkg::FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0] in_base,
   input  logic [dvec_pkg::NUM_EDGES-1:0]                 in_cross,
   input  logic [SCALAR_BITS-1:0]                         in_num [dvec_pkg::NUM_EDGES],
   input  logic [SCALAR_BITS-1:0]                         in_den [dvec_pkg::NUM_EDGES],
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0] out_base,
   output logic [dvec_pkg::NUM_EDGES-1:0]                 out_cross,
   output logic [FRAC_BITS:0]                             out_quo [dvec_pkg::NUM_EDGES]
);

   localparam int STAGES = FRAC_BITS + 1;

   logic [STAGES-1:0]                               valid_ff;
   logic [STAGES:0]                                 stage_ready;
   logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]  base_ff  [STAGES];
   logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]  base_in  [STAGES];
   logic [dvec_pkg::NUM_EDGES-1:0]                  cross_ff [STAGES];
   logic [dvec_pkg::NUM_EDGES-1:0]                  cross_in [STAGES];
   logic [STAGES-1:0]                               valid_in;
   logic [SCALAR_BITS-1:0] den_ff [STAGES][dvec_pkg::NUM_EDGES];
   logic [SCALAR_BITS-1:0] den_in [STAGES][dvec_pkg::NUM_EDGES];
   logic [SCALAR_BITS-1:0] rem_ff [STAGES][dvec_pkg::NUM_EDGES];
   logic [SCALAR_BITS-1:0] rem_in [STAGES][dvec_pkg::NUM_EDGES];
   logic [FRAC_BITS:0]     quo_ff [STAGES][dvec_pkg::NUM_EDGES];
   logic [FRAC_BITS:0]     quo_in [STAGES][dvec_pkg::NUM_EDGES];

   assign stage_ready[STAGES] = out_ready;
   assign in_ready            = stage_ready[0];
   assign out_valid           = valid_ff[STAGES-1];
   assign out_base            = base_ff[STAGES-1];
   assign out_cross           = cross_ff[STAGES-1];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      assign stage_ready[j] = !valid_ff[j] || stage_ready[j+1];

      if (j == 0) begin : g_first
         assign valid_in[j] = in_valid;
         assign base_in[j]  = in_base;
         assign cross_in[j] = in_cross;
      end else begin : g_next
         assign valid_in[j] = valid_ff[j-1];
         assign base_in[j]  = base_ff[j-1];
         assign cross_in[j] = cross_ff[j-1];
      end

      for (genvar e = 0; e < dvec_pkg::NUM_EDGES; e++) begin : g_lane
         logic [SCALAR_BITS-1:0] den_src;
         logic [FRAC_BITS:0]     quo_src;
         logic [SCALAR_BITS:0]   trial;
         logic [SCALAR_BITS:0]   diff;
         logic                   ge;

         // the first step weighs 2^FRAC_BITS, later steps shift the remainder
         if (j == 0) begin : g_first
            assign den_src = in_den[e];
            assign quo_src = '0;
            assign trial   = {1'b0, in_num[e]};
         end else begin : g_next
            assign den_src = den_ff[j-1][e];
            assign quo_src = quo_ff[j-1][e];
            assign trial   = {rem_ff[j-1][e], 1'b0};
         end

         assign diff         = trial - {1'b0, den_src};
         assign ge           = trial >= {1'b0, den_src};
         assign den_in[j][e] = den_src;
         assign rem_in[j][e] = ge ? diff[SCALAR_BITS-1:0] : trial[SCALAR_BITS-1:0];
         assign quo_in[j][e] = {quo_src[FRAC_BITS-1:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int j = 0; j < STAGES; j++) begin
            if (stage_ready[j]) begin
               valid_ff[j] <= valid_in[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < STAGES; j++) begin
         if (stage_ready[j]) begin
            base_ff[j]  <= base_in[j];
            cross_ff[j] <= cross_in[j];
            den_ff[j]   <= den_in[j];
            rem_ff[j]   <= rem_in[j];
            quo_ff[j]   <= quo_in[j];
         end
      end
   end

   always_comb begin
      for (int e = 0; e < dvec_pkg::NUM_EDGES; e++) begin
         out_quo[e] = quo_ff[STAGES-1][e];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dvec_sum.sv -----
// ----------------------------------------------------------------------------
// dvec_sum
// Adds the crossing fractions per axis relative to the cube base and counts them.
// ----------------------------------------------------------------------------
`default_nettype none

module dvec_sum #(
   parameter int COORD_BITS = dvec_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dvec_pkg::FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0] in_base,
   input  logic [dvec_pkg::NUM_EDGES-1:0]                 in_cross,
   input  logic [FRAC_BITS:0]                             in_quo [dvec_pkg::NUM_EDGES],
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0] out_base,
   output logic [dvec_pkg::DIMENSION-1:0][FRAC_BITS+3:0]  out_sum,
   output logic [dvec_pkg::COUNT_BITS-1:0]                out_count
);

   localparam int SUM_BITS = FRAC_BITS + 4;

   logic                                          valid_ff;
   logic [dvec_pkg::DIMENSION-1:0][SUM_BITS-1:0]  sum_in;
   logic [dvec_pkg::COUNT_BITS-1:0]               count_in;

   for (genvar a = 0; a < dvec_pkg::DIMENSION; a++) begin : g_axis
      logic [SUM_BITS-1:0]             q_term [dvec_pkg::EDGES_PER_AXIS];
      logic [dvec_pkg::NUM_EDGES-1:0]  ofs_mask;
      logic [dvec_pkg::COUNT_BITS-1:0] ofs_cnt;

      for (genvar i = 0; i < dvec_pkg::EDGES_PER_AXIS; i++) begin : g_along
         localparam int E = a * dvec_pkg::EDGES_PER_AXIS + i;
         assign q_term[i] = in_cross[E] ? SUM_BITS'(in_quo[E]) : '0;
      end

      // crossings on other axes at the upper face of this axis add one whole unit
      for (genvar e = 0; e < dvec_pkg::NUM_EDGES; e++) begin : g_across
         assign ofs_mask[e] = in_cross[e] && (dvec_pkg::EDGE_AXIS[e] != 2'(a))
                              && dvec_pkg::EDGE_LO_CORNER[e][a];
      end

      assign ofs_cnt   = dvec_pkg::COUNT_BITS'($countones(ofs_mask));
      assign sum_in[a] = q_term[0] + q_term[1] + q_term[2] + q_term[3]
                       + (SUM_BITS'(ofs_cnt) << FRAC_BITS);
   end

   assign count_in  = dvec_pkg::COUNT_BITS'($countones(in_cross));
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         out_base  <= in_base;
         out_sum   <= sum_in;
         out_count <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dvec_mean_div.sv -----
// ----------------------------------------------------------------------------
// dvec_mean_div
// Divides the axis sums by the crossing count and forms the vertex position.
// ----------------------------------------------------------------------------
`default_nettype none

module dvec_mean_div #(
   parameter int COORD_BITS = dvec_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dvec_pkg::FRAC_BITS_DEF
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  logic                                                     in_valid,
   output logic                                                     in_ready,
   input  logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]           in_base,
   input  logic [dvec_pkg::DIMENSION-1:0][FRAC_BITS+3:0]            in_sum,
   input  logic [dvec_pkg::COUNT_BITS-1:0]                          in_count,
   output logic                                                     out_valid,
   input  logic                                                     out_ready,
   output logic [dvec_pkg::DIMENSION-1:0][COORD_BITS+FRAC_BITS:0]   out_pos,
   output logic [dvec_pkg::COUNT_BITS-1:0]                          out_count
);

   localparam int STAGES   = FRAC_BITS + 4;
   localparam int POS_BITS = COORD_BITS + FRAC_BITS + 1;
   localparam logic [POS_BITS-1:0] HALF = POS_BITS'(1) << (FRAC_BITS - 1);

   typedef logic [dvec_pkg::DIMENSION-1:0][STAGES-1:0]             acc_type;
   typedef logic [dvec_pkg::DIMENSION-1:0][dvec_pkg::REM_BITS-1:0] rem_type;

   logic [STAGES-1:0]                               valid_ff;
   logic [STAGES-1:0]                               valid_in;
   logic [STAGES:0]                                 stage_ready;
   logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]  base_ff  [STAGES];
   logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]  base_in  [STAGES];
   logic [dvec_pkg::COUNT_BITS-1:0]                 count_ff [STAGES];
   logic [dvec_pkg::COUNT_BITS-1:0]                 count_in [STAGES];
   acc_type                                         acc_ff   [STAGES];
   acc_type                                         acc_in   [STAGES];
   rem_type                                         rem_ff   [STAGES];
   rem_type                                         rem_in   [STAGES];

   logic                                               pos_valid_ff;
   logic [dvec_pkg::DIMENSION-1:0][POS_BITS-1:0]       pos_in;

   assign in_ready = stage_ready[0];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      acc_type                         acc_src;
      rem_type                         rem_src;
      logic [dvec_pkg::COUNT_BITS-1:0] count_src;

      assign stage_ready[j] = !valid_ff[j] || stage_ready[j+1];

      if (j == 0) begin : g_first
         assign valid_in[j] = in_valid;
         assign base_in[j]  = in_base;
         assign count_src   = in_count;
         assign acc_src     = in_sum;
         assign rem_src     = '0;
      end else begin : g_next
         assign valid_in[j] = valid_ff[j-1];
         assign base_in[j]  = base_ff[j-1];
         assign count_src   = count_ff[j-1];
         assign acc_src     = acc_ff[j-1];
         assign rem_src     = rem_ff[j-1];
      end
      assign count_in[j] = count_src;

      // shift one dividend bit into the remainder, the quotient bit into the word
      for (genvar a = 0; a < dvec_pkg::DIMENSION; a++) begin : g_axis
         logic [dvec_pkg::REM_BITS:0] trial;
         logic [dvec_pkg::REM_BITS:0] diff;
         logic                        ge;

         assign trial           = {rem_src[a], acc_src[a][STAGES-1]};
         assign diff            = trial - {1'b0, count_src};
         assign ge              = trial >= {1'b0, count_src};
         assign rem_in[j][a]    = ge ? diff[dvec_pkg::REM_BITS-1:0]
                                     : trial[dvec_pkg::REM_BITS-1:0];
         assign acc_in[j][a]    = {acc_src[a][STAGES-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int j = 0; j < STAGES; j++) begin
            if (stage_ready[j]) begin
               valid_ff[j] <= valid_in[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < STAGES; j++) begin
         if (stage_ready[j]) begin
            base_ff[j]  <= base_in[j];
            count_ff[j] <= count_in[j];
            acc_ff[j]   <= acc_in[j];
            rem_ff[j]   <= rem_in[j];
         end
      end
   end

   // output register: base plus mean fraction, or the cube centre with no crossing
   assign stage_ready[STAGES] = !pos_valid_ff || out_ready;
   assign out_valid           = pos_valid_ff;

   always_comb begin
      for (int a = 0; a < dvec_pkg::DIMENSION; a++) begin
         pos_in[a] = POS_BITS'({base_ff[STAGES-1][a], {FRAC_BITS{1'b0}}})
                   + ((count_ff[STAGES-1] == '0) ? HALF
                      : POS_BITS'(acc_ff[STAGES-1][a][FRAC_BITS:0]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff <= 1'b0;
      end else if (stage_ready[STAGES]) begin
         pos_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[STAGES]) begin
         out_pos   <= pos_in;
         out_count <= count_ff[STAGES-1];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dual_vertex_edge_centroid_top.sv -----
// ----------------------------------------------------------------------------
// dual_vertex_edge_centroid_top
// Surface-nets vertex placement at the centroid of a cube's edge crossings.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one grid cube per request: base coordinates and the eight
//   corner scalars. rsp_chan returns one vertex position per request, in order,
//   as unsigned fixed point with FRAC_BITS fraction bits, and the crossing count.
//   csr_chan writes the isovalue; it is always ready and should be written only
//   while no request is in flight.
// Throughput: one request per cycle while rsp_chan does not stall.
// Path: from acceptance a request passes the prep register, the
//   one-bit-per-stage edge divider (FRAC_BITS+1 stages), the sum register,
//   the count divider (FRAC_BITS+4 stages) and its output register to rsp valid.
// Stall: every stage holds while the stage after it is full and stalled; empty
//   stages still fill, so requests are taken until the whole pipeline is full.
// Reset: synchronous; empties the pipeline and sets the isovalue to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_vertex_edge_centroid_top #(
   parameter int COORD_BITS  = dvec_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS   = dvec_pkg::FRAC_BITS_DEF,
   parameter int SCALAR_BITS = dvec_pkg::SCALAR_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dvec_req_if.sink   req_chan,
   dvec_rsp_if.source rsp_chan,
   dvec_csr_if.sink   csr_chan
);

   localparam int POS_BITS  = COORD_BITS + FRAC_BITS + 1;
   localparam int SUM_BITS  = FRAC_BITS + 4;

   logic signed [SCALAR_BITS-1:0]                   iso_ff;
   logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]  req_base;
   logic signed [SCALAR_BITS-1:0]                   req_corner [dvec_pkg::NUM_CORNERS];

   logic                                            prep_valid, prep_ready;
   logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]  prep_base;
   logic [dvec_pkg::NUM_EDGES-1:0]                  prep_cross;
   logic [SCALAR_BITS-1:0]                          prep_num [dvec_pkg::NUM_EDGES];
   logic [SCALAR_BITS-1:0]                          prep_den [dvec_pkg::NUM_EDGES];

   logic                                            div_valid, div_ready;
   logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]  div_base;
   logic [dvec_pkg::NUM_EDGES-1:0]                  div_cross;
   logic [FRAC_BITS:0]                              div_quo [dvec_pkg::NUM_EDGES];

   logic                                            sum_valid, sum_ready;
   logic [dvec_pkg::DIMENSION-1:0][COORD_BITS-1:0]  sum_base;
   logic [dvec_pkg::DIMENSION-1:0][SUM_BITS-1:0]    sum_val;
   logic [dvec_pkg::COUNT_BITS-1:0]                 sum_count;

   logic [dvec_pkg::DIMENSION-1:0][POS_BITS-1:0]    mean_pos;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff <= '0;
      end else if (csr_chan.valid) begin
         iso_ff <= csr_chan.data;
      end
   end

   assign req_base[0]   = req_chan.cube_x;
   assign req_base[1]   = req_chan.cube_y;
   assign req_base[2]   = req_chan.cube_z;
   assign req_corner[0] = req_chan.corner_value_0;
   assign req_corner[1] = req_chan.corner_value_1;
   assign req_corner[2] = req_chan.corner_value_2;
   assign req_corner[3] = req_chan.corner_value_3;
   assign req_corner[4] = req_chan.corner_value_4;
   assign req_corner[5] = req_chan.corner_value_5;
   assign req_corner[6] = req_chan.corner_value_6;
   assign req_corner[7] = req_chan.corner_value_7;

   dvec_prep #(
      .COORD_BITS  (COORD_BITS),
      .SCALAR_BITS (SCALAR_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .iso_level (iso_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_base   (req_base),
      .in_corner (req_corner),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_base  (prep_base),
      .out_cross (prep_cross),
      .out_num   (prep_num),
      .out_den   (prep_den)
   );

   dvec_edge_div #(
      .COORD_BITS  (COORD_BITS),
      .SCALAR_BITS (SCALAR_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_edge_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_base   (prep_base),
      .in_cross  (prep_cross),
      .in_num    (prep_num),
      .in_den    (prep_den),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_base  (div_base),
      .out_cross (div_cross),
      .out_quo   (div_quo)
   );

   dvec_sum #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_base   (div_base),
      .in_cross  (div_cross),
      .in_quo    (div_quo),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_base  (sum_base),
      .out_sum   (sum_val),
      .out_count (sum_count)
   );

   dvec_mean_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_base   (sum_base),
      .in_sum    (sum_val),
      .in_count  (sum_count),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_pos   (mean_pos),
      .out_count (rsp_chan.crossing_count)
   );

   assign rsp_chan.pos_x = mean_pos[0];
   assign rsp_chan.pos_y = mean_pos[1];
   assign rsp_chan.pos_z = mean_pos[2];

endmodule

`default_nettype wire

// ----- rtl/dvec_checker.sv -----
// ----------------------------------------------------------------------------
// dvec_checker
// Port-level checks on the response channel of the centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_vertex_edge_centroid_top_assert.svh"

module dvec_checker #(
   parameter int FRAC_BITS = dvec_pkg::FRAC_BITS_DEF,
   parameter int POS_BITS  = dvec_pkg::COORD_BITS_DEF + dvec_pkg::FRAC_BITS_DEF + 1
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [POS_BITS-1:0]             rsp_pos_x,
   input wire logic [dvec_pkg::COUNT_BITS-1:0] rsp_count
);

   localparam logic [FRAC_BITS-1:0] CENTRE_FRAC = FRAC_BITS'(1) << (FRAC_BITS - 1);

   // a stalled response holds
   `DVEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pos_x) && $stable(rsp_count))

   // reset drains the pipeline
   `DVEC_ASSERT_IMPLY(a_reset_empty, clock, 1'b0, $past(reset) && !reset, !rsp_valid)

   // the crossing count never exceeds the number of cube edges
   `DVEC_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, rsp_count <= dvec_pkg::COUNT_BITS'(dvec_pkg::NUM_EDGES))

   // no crossing places the vertex at the cube centre (checked on x)
   `DVEC_ASSERT_IMPLY(a_centre, clock, reset, rsp_valid && rsp_count == '0, rsp_pos_x[FRAC_BITS-1:0] == CENTRE_FRAC)

endmodule

bind dual_vertex_edge_centroid_top dvec_checker #(
   .FRAC_BITS (FRAC_BITS),
   .POS_BITS  (COORD_BITS + FRAC_BITS + 1)
) u_dvec_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_pos_x (rsp_chan.pos_x),
   .rsp_count (rsp_chan.crossing_count)
);

`default_nettype wire

// ----- tb/sv/tb_dual_vertex_edge_centroid_top.sv -----
// ----------------------------------------------------------------------------
// tb_dual_vertex_edge_centroid_top
// Streams grid cubes into the centroid block under several isovalues and
// idling patterns, predicts each vertex position and count, and checks every
// response in order against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

class centroid_scoreboard;
   typedef struct packed {
      logic [26:0] px;
      logic [26:0] py;
      logic [26:0] pz;
      logic [3:0]  cnt;
   } vertex_type;

   vertex_type pending[$];
   int      errors;
   logic signed [15:0] iso;

   function new();
      errors = 0;
      iso = '0;
   endfunction

   function void note_cube(logic [9:0] bx, logic [9:0] by, logic [9:0] bz,
                           logic signed [15:0] cv[8]);
      longint  base[3];
      longint  acc[3];
      longint  c, num, den, s0, s1;
      int      cnt, k1;
      vertex_type v;
      base[0] = longint'(bx) << 16;
      base[1] = longint'(by) << 16;
      base[2] = longint'(bz) << 16;
      acc = '{0, 0, 0};
      cnt = 0;
      for (int d = 0; d < 3; d++) begin
         for (int k = 0; k < 8; k++) begin
            if (k[d]) continue;
            k1 = k | (1 << d);
            s0 = cv[k];
            s1 = cv[k1];
            if ((s0 >= iso) == (s1 >= iso)) continue;
            for (int a = 0; a < 3; a++) begin
               c = base[a];
               if (a == d) begin
                  num = (iso >= s0) ? iso - s0 : s0 - iso;
                  den = (s1 >= s0) ? s1 - s0 : s0 - s1;
                  if (den != 0) c += (num << 16) / den;
               end else if (k[a]) begin
                  c += 1 << 16;
               end
               acc[a] += c;
            end
            cnt++;
         end
      end
      for (int a = 0; a < 3; a++)
         acc[a] = (cnt > 0) ? acc[a] / cnt : base[a] + (1 << 15);
      v.px = acc[0][26:0];
      v.py = acc[1][26:0];
      v.pz = acc[2][26:0];
      v.cnt = cnt[3:0];
      pending.push_back(v);
   endfunction

   function void check_vertex(logic [26:0] px, logic [26:0] py, logic [26:0] pz,
                              logic [3:0] cnt);
      vertex_type e;
      if (pending.size() == 0) begin
         errors++;
         $display("%0t: unexpected response px=%h py=%h pz=%h cnt=%0d",
                  $time, px, py, pz, cnt);
         return;
      end
      e = pending.pop_front();
      if (px !== e.px || py !== e.py || pz !== e.pz || cnt !== e.cnt) begin
         errors++;
         $display("%0t: mismatch expected px=%h py=%h pz=%h cnt=%0d actual px=%h py=%h pz=%h cnt=%0d",
                  $time, e.px, e.py, e.pz, e.cnt, px, py, pz, cnt);
      end
   endfunction
endclass

module tb_dual_vertex_edge_centroid_top;

   localparam int LATENCY = 2 * dvec_pkg::FRAC_BITS_DEF + 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   stall_pct = 0;

   dvec_req_if req_chan ();
   dvec_rsp_if rsp_chan ();
   dvec_csr_if csr_chan ();

   centroid_scoreboard vertex_board = new();

   dual_vertex_edge_centroid_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.cube_x = '0;
      req_chan.cube_y = '0;
      req_chan.cube_z = '0;
      req_chan.corner_value_0 = '0;
      req_chan.corner_value_1 = '0;
      req_chan.corner_value_2 = '0;
      req_chan.corner_value_3 = '0;
      req_chan.corner_value_4 = '0;
      req_chan.corner_value_5 = '0;
      req_chan.corner_value_6 = '0;
      req_chan.corner_value_7 = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
   end

   // receiver: stall at random, check each accepted response
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         vertex_board.check_vertex(rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.pos_z,
                                   rsp_chan.crossing_count);
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic write_iso(input logic signed [15:0] level);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= level;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      vertex_board.iso = level;
   endtask

   task automatic send_cube(input logic [9:0] bx, input logic [9:0] by,
                            input logic [9:0] bz, input logic signed [15:0] cv[8]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cube_x <= bx;
      req_chan.cube_y <= by;
      req_chan.cube_z <= bz;
      req_chan.corner_value_0 <= cv[0];
      req_chan.corner_value_1 <= cv[1];
      req_chan.corner_value_2 <= cv[2];
      req_chan.corner_value_3 <= cv[3];
      req_chan.corner_value_4 <= cv[4];
      req_chan.corner_value_5 <= cv[5];
      req_chan.corner_value_6 <= cv[6];
      req_chan.corner_value_7 <= cv[7];
      do @(posedge clock); while (!req_chan.ready);
      vertex_board.note_cube(bx, by, bz, cv);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (vertex_board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // random scalar: half near the isovalue so edges cross, the rest random or extreme
   function automatic logic signed [15:0] near_iso();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 16'sh7fff;
      if (r == 1) return 16'sh8000;
      if (r < 5) return 16'($urandom);
      return vertex_board.iso + $signed(16'($urandom_range(400))) - 16'sd200;
   endfunction

   task automatic random_cubes(input int n);
      logic signed [15:0] cv[8];
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < 8; k++) cv[k] = near_iso();
         send_cube(10'($urandom), 10'($urandom), 10'($urandom), cv);
      end
   endtask

   initial begin
      logic signed [15:0] cv[8];
      logic signed [15:0] levels[5];
      levels = '{16'sd0, 16'sh8000, 16'sh7fff, -16'sd1000, 16'sd1234};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no crossing, all crossings, one corner cut off, extreme values
      cv = '{default: 16'sd5};
      send_cube(10'd0, 10'd0, 10'd0, cv);
      cv = '{default: -16'sd5};
      send_cube(10'h3ff, 10'h3ff, 10'h3ff, cv);
      cv = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
             16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
      send_cube(10'h3ff, 10'd0, 10'h2aa, cv);
      cv = '{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
      send_cube(10'h155, 10'h3ff, 10'd0, cv);
      cv = '{16'sd0, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1};
      send_cube(10'd7, 10'd9, 10'h3ff, cv);
      for (int c = 0; c < 8; c++) begin
         cv = '{default: 16'sh8000};
         cv[c] = 16'sh7fff;
         send_cube(10'(c * 100), 10'(1023 - c), 10'(c), cv);
      end
      drain();

      for (int p = 0; p < 5; p++) begin
         write_iso(levels[p]);
         case (p)
            1: begin send_idle_pct = 63; stall_pct = 0; end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            3: begin send_idle_pct = 38; stall_pct = 38; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         // every corner exactly on this isovalue
         cv = '{default: levels[p]};
         send_cube(10'd1, 10'd2, 10'd3, cv);
         random_cubes(160);
         drain();
      end

      if (vertex_board.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/dvec_pkg.sv
rtl/dvec_if.sv
rtl/dvec_prep.sv
rtl/dvec_edge_div.sv
rtl/dvec_sum.sv
rtl/dvec_mean_div.sv
rtl/dual_vertex_edge_centroid_top.sv
rtl/dvec_checker.sv
tb/sv/tb_dual_vertex_edge_centroid_top.sv
